// File: rtl/core/tmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank package
// Shared constants, codes and item types of the tick timer bank.
// ----------------------------------------------------------------------------
package tmb_pkg;

  localparam int TIMERS      = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W       = $clog2(TIMERS + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W      = 3;
  localparam int ID_W        = 8;
  localparam int PERIOD_W    = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [PERIOD_W-1:0] period_t;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_CREATE = 2'd0,
    EV_CTRL   = 2'd1,
    EV_EXPIRE = 2'd2
  } kind_t;

  typedef struct packed {
    op_t     op;
    logic    id_ok;
    idx_t    id;
    logic    mode;
    period_t period;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    slot_t slot;
    logic  failed;
    logic  last;
  } res_t;

endpackage

// File: rtl/core/tmb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank front end
// Decodes incoming items into commands and queues them for the back end.
// ----------------------------------------------------------------------------
module tmb_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               func,
  input  logic [tmb_pkg::ID_W-1:0] timer_id,
  input  logic                     repeat_mode,
  input  tmb_pkg::period_t         period_ticks,
  output logic                     q_valid,
  input  logic                     q_pop,
  output tmb_pkg::cmd_t            q_cmd
);

  tmb_pkg::cmd_t                     cmd_in;
  tmb_pkg::cmd_t                     queue [tmb_pkg::QUEUE_DEPTH];
  logic [tmb_pkg::QPTR_W-1:0]        wr_ptr;
  logic [tmb_pkg::QPTR_W-1:0]        rd_ptr;
  logic [tmb_pkg::QCNT_W-1:0]        count;
  logic                              push;
  logic                              pop;

  always_comb begin
    cmd_in.op     = tmb_pkg::op_t'(func);
    cmd_in.id_ok  = {1'b0, timer_id} < (tmb_pkg::ID_W + 1)'(tmb_pkg::TIMERS);
    cmd_in.id     = tmb_pkg::idx_t'(timer_id);
    cmd_in.mode   = repeat_mode;
    cmd_in.period = period_ticks;
  end

  assign in_ready = count != tmb_pkg::QCNT_W'(tmb_pkg::QUEUE_DEPTH);
  assign q_valid  = count != '0;
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_cmd    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/tmb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank back end
// Holds the timer store, executes commands and walks the bank on each tick.
// ----------------------------------------------------------------------------
module tmb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  tmb_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output tmb_pkg::res_t out_res
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t                        st;
  tmb_pkg::period_t              reload_value [tmb_pkg::TIMERS];
  tmb_pkg::period_t              remaining [tmb_pkg::TIMERS];
  logic [tmb_pkg::TIMERS-1:0]    periodic;
  logic [tmb_pkg::TIMERS-1:0]    armed;
  tmb_pkg::cnt_t                 created_count;
  tmb_pkg::cnt_t                 walk_idx;
  logic [tmb_pkg::NRES_W-1:0]    n_rep;
  logic                          pend_valid;
  tmb_pkg::idx_t                 pend_slot;

  tmb_pkg::idx_t                 cur;
  tmb_pkg::idx_t                 new_idx;
  tmb_pkg::period_t              rem;
  tmb_pkg::period_t              dec;
  logic                          hit;
  logic                          report;
  logic                          walk_more;
  logic                          out_free;
  logic                          step_ok;
  logic                          take;
  logic                          create_fail;
  logic                          load_out;
  tmb_pkg::res_t                 out_next;

  always_comb begin
    out_free    = !out_valid || out_ready;
    cur         = tmb_pkg::idx_t'(walk_idx);
    new_idx     = tmb_pkg::idx_t'(created_count);
    rem         = remaining[cur];
    dec         = (rem != '0) ? rem - 1'b1 : '0;
    hit         = armed[cur] && (dec == '0);
    report      = hit && (n_rep < tmb_pkg::NRES_W'(tmb_pkg::MAX_RESULTS));
    walk_more   = walk_idx < created_count;
    step_ok     = !(report && pend_valid && !out_free);
    take        = (st == ST_IDLE) && q_valid && out_free;
    create_fail = created_count >= tmb_pkg::CNT_W'(tmb_pkg::TIMERS);
    q_pop       = take;

    load_out        = 1'b0;
    out_next.kind   = tmb_pkg::EV_EXPIRE;
    out_next.slot   = tmb_pkg::slot_t'(pend_slot);
    out_next.failed = 1'b0;
    out_next.last   = 1'b0;
    case (st)
      ST_IDLE: begin
        if (take && q_cmd.op != tmb_pkg::OP_TICK) begin
          load_out      = 1'b1;
          out_next.last = 1'b1;
          if (q_cmd.op == tmb_pkg::OP_CREATE) begin
            out_next.kind   = tmb_pkg::EV_CREATE;
            out_next.failed = create_fail;
            out_next.slot   = create_fail ? '0 : tmb_pkg::slot_t'(created_count);
          end else begin
            out_next.kind   = tmb_pkg::EV_CTRL;
            out_next.failed = !q_cmd.id_ok;
            out_next.slot   = q_cmd.id_ok ? tmb_pkg::slot_t'(q_cmd.id) : '0;
          end
        end
      end
      ST_WALK: begin
        if (walk_more) begin
          load_out = report && pend_valid && step_ok;
        end else begin
          load_out      = pend_valid && out_free;
          out_next.last = 1'b1;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      created_count <= '0;
      armed         <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      walk_idx      <= '0;
      n_rep         <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (take) begin
            case (q_cmd.op)
              tmb_pkg::OP_CREATE: begin
                if (!create_fail) begin
                  created_count  <= created_count + 1'b1;
                  armed[new_idx] <= 1'b1;
                end
              end
              tmb_pkg::OP_START: begin
                if (q_cmd.id_ok) begin
                  armed[q_cmd.id] <= 1'b1;
                end
              end
              tmb_pkg::OP_STOP: begin
                if (q_cmd.id_ok) begin
                  armed[q_cmd.id] <= 1'b0;
                end
              end
              tmb_pkg::OP_TICK: begin
                st         <= ST_WALK;
                walk_idx   <= '0;
                n_rep      <= '0;
                pend_valid <= 1'b0;
              end
              default: begin
                st <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (walk_more) begin
            if (step_ok) begin
              walk_idx <= walk_idx + 1'b1;
              if (hit && !periodic[cur]) begin
                armed[cur] <= 1'b0;
              end
              if (report) begin
                pend_valid <= 1'b1;
                n_rep      <= n_rep + 1'b1;
              end
            end
          end else if (!pend_valid || out_free) begin
            st         <= ST_IDLE;
            pend_valid <= 1'b0;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= out_next;
    end
    if (st == ST_WALK && walk_more && step_ok && report) begin
      pend_slot <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_cmd.op == tmb_pkg::OP_CREATE && !create_fail) begin
      reload_value[new_idx] <= q_cmd.period;
      remaining[new_idx]    <= q_cmd.period;
      periodic[new_idx]     <= q_cmd.mode;
    end else if (take && q_cmd.op == tmb_pkg::OP_START && q_cmd.id_ok) begin
      remaining[q_cmd.id] <= reload_value[q_cmd.id];
    end else if (st == ST_WALK && walk_more && step_ok && armed[cur]) begin
      remaining[cur] <= (hit && periodic[cur]) ? reload_value[cur] : dec;
    end
  end

endmodule

// File: rtl/core/multi_channel_tick_timer_bank_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel tick timer bank
// Bank of one-shot and periodic countdown timers driven by a command stream.
// ----------------------------------------------------------------------------
// Create, start and stop pass through the queue and the output register, one item per
// cycle while the output is free and no tick is walked. A tick walks the created
// timers, one timer store entry per cycle unless an expiry result is held by the output.
// A two-item queue lets the front end keep accepting while a tick is walked.
// Synchronous reset empties the queue, clears all armed flags and the count.
// ----------------------------------------------------------------------------
module multi_channel_tick_timer_bank_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // timer_id[7:0], repeat_mode[8], period_ticks[40:9]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // slot[2:0], failed[3]
  output logic [1:0]  m_tuser,   // event_kind[1:0]
  output logic        m_tlast    // last_of_run
);

  logic          q_valid;
  logic          q_pop;
  tmb_pkg::cmd_t q_cmd;
  tmb_pkg::res_t res;

  tmb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .func         (s_tuser),
    .timer_id     (s_tdata[7:0]),
    .repeat_mode  (s_tdata[8]),
    .period_ticks (s_tdata[40:9]),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cmd        (q_cmd)
  );

  tmb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {4'b0000, res.failed, res.slot};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

// File: rtl/core/tmb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank port checker
// Checks the result stream of the timer bank as seen on its ports.
// ----------------------------------------------------------------------------
module tmb_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result item changed while stalled");

  a_cmd_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != tmb_pkg::EV_EXPIRE |-> m_tlast)
    else $error("command result not marked last");

  a_expire_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tmb_pkg::EV_EXPIRE |-> !m_tdata[3])
    else $error("expiry result flagged as failed");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2:0] == 3'd0)
    else $error("failed result carries a nonzero slot");

endmodule

bind multi_channel_tick_timer_bank_top tmb_checker u_tmb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick timer bank testbench
// Drives create, start, stop and tick items into the timer bank and checks
// every event against a cycle-free model of the bank kept in this file.
// A directed opening is followed by random traffic, random stalls on both
// sides, one long output hold-off and one full drain pause.
// ----------------------------------------------------------------------------
module tb;
  import tmb_pkg::*;

  localparam int LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  period_t reload_val [TIMERS];
  period_t count_left [TIMERS];
  logic    is_periodic [TIMERS];
  logic    is_armed [TIMERS];
  int      made_cnt;

  res_t pending_events[$];
  res_t got_ev;
  res_t want_ev;

  int  fail_cnt = 0;
  int  n_items = 0;
  int  n_events = 0;
  int  n_expiries = 0;
  int  cyc = 0;
  int  hold_cycles = 0;
  bit  idle_on = 1'b1;

  multi_channel_tick_timer_bank_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("multi_channel_tick_timer_bank_top regression: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void post_event(kind_t k, int slot, logic failed, logic last);
    res_t e;
    e.kind   = k;
    e.slot   = slot_t'(slot);
    e.failed = failed;
    e.last   = last;
    pending_events.push_back(e);
  endfunction

  // Applies one accepted item to the bank image and queues the events it causes.
  function automatic void bank_apply(op_t op, logic [7:0] id, logic mode, period_t period);
    int   n;
    res_t e;
    n = 0;
    case (op)
      OP_CREATE: begin
        if (made_cnt >= TIMERS) begin
          post_event(EV_CREATE, 0, 1'b1, 1'b1);
        end else begin
          is_periodic[made_cnt] = mode;
          reload_val[made_cnt]  = period;
          count_left[made_cnt]  = period;
          is_armed[made_cnt]    = 1'b1;
          post_event(EV_CREATE, made_cnt, 1'b0, 1'b1);
          made_cnt++;
        end
      end
      OP_START, OP_STOP: begin
        if (id >= TIMERS) begin
          post_event(EV_CTRL, 0, 1'b1, 1'b1);
        end else begin
          if (op == OP_START) begin
            count_left[id] = reload_val[id];
            is_armed[id]   = 1'b1;
          end else begin
            is_armed[id] = 1'b0;
          end
          post_event(EV_CTRL, id, 1'b0, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < made_cnt; i++) begin
          if (is_armed[i]) begin
            if (count_left[i] != 0) count_left[i] = count_left[i] - 1;
            if (count_left[i] == 0) begin
              if (n < MAX_RESULTS) begin
                post_event(EV_EXPIRE, i, 1'b0, 1'b0);
                n++;
              end
              if (is_periodic[i]) count_left[i] = reload_val[i];
              else is_armed[i] = 1'b0;
            end
          end
        end
        if (n > 0) begin
          e = pending_events.pop_back();
          e.last = 1'b1;
          pending_events.push_back(e);
        end
      end
    endcase
  endfunction

  // Offers one item and returns in the time step of the edge that accepts it.
  task automatic send_item(op_t op, logic [7:0] id, logic mode, period_t period);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, period, mode, id};
    do @(negedge clk); while (!s_tready);
    bank_apply(op, id, mode, period);
    n_items++;
    @(posedge clk);
  endtask

  task automatic send_random();
    int         r;
    logic [7:0] id;
    logic       mode;
    period_t    period;
    r      = $urandom_range(0, 99);
    id     = 8'($urandom_range(0, 255));
    mode   = 1'($urandom_range(0, 1));
    period = $urandom();
    if (r < 45) begin
      send_item(OP_TICK, id, mode, period);
    end else if (r < 65) begin
      if (made_cnt > 0) id = 8'($urandom_range(0, made_cnt - 1));
      else id = 8'($urandom_range(TIMERS, 255));
      send_item(OP_START, id, mode, period);
    end else if (r < 80) begin
      send_item(OP_STOP, 8'($urandom_range(0, TIMERS - 1)), mode, period);
    end else if (r < 90) begin
      send_item(r[0] ? OP_START : OP_STOP, 8'($urandom_range(TIMERS, 255)), mode, period);
    end else begin
      if (made_cnt < TIMERS && $urandom_range(0, 7) != 0) period = $urandom_range(0, 6);
      send_item(OP_CREATE, id, mode, period);
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
    send_item(OP_STOP, 8'd0, 1'b0, 32'd0);
    send_item(OP_START, 8'd8, 1'b0, 32'd0);
    send_item(OP_STOP, 8'd255, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_CREATE, 8'd0, 1'b1, 32'd0);
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
    send_item(OP_CREATE, 8'd0, 1'b0, 32'd1);
    send_item(OP_CREATE, 8'd0, 1'b1, 32'd3);
    send_item(OP_CREATE, 8'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
    send_item(OP_STOP, 8'd0, 1'b0, 32'd0);
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
    send_item(OP_START, 8'd1, 1'b0, 32'd0);
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
    send_item(OP_START, 8'd0, 1'b0, 32'd0);
    send_item(OP_TICK, 8'd255, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_bank();
    while (made_cnt < TIMERS - 1) begin
      send_item(OP_CREATE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 5));
    end
    send_item(OP_CREATE, 8'd0, 1'b0, 32'd0);
    send_item(OP_CREATE, 8'($urandom_range(0, 255)), 1'b1, $urandom());
    send_item(OP_CREATE, 8'($urandom_range(0, 255)), 1'b0, $urandom());
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
    send_item(OP_TICK, 8'd0, 1'b0, 32'd0);
  endtask

  task automatic test_random(int count, bit with_idle);
    idle_on = with_idle;
    repeat (count) send_random();
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    hold_cycles = 150;
    idle_on = 1'b0;
    repeat (16) send_random();
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    wait_drain();
    repeat (10) send_random();
  endtask

  // The output side stalls at random, or for a long fixed stretch on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!idle_on || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready   <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_ev.kind   = kind_t'(m_tuser);
      got_ev.slot   = m_tdata[2:0];
      got_ev.failed = m_tdata[3];
      got_ev.last   = m_tlast;
      n_events++;
      if (got_ev.kind == EV_EXPIRE) n_expiries++;
      if (pending_events.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected event: kind %0d slot %0d failed %0b last %0b",
                   got_ev.kind, got_ev.slot, got_ev.failed, got_ev.last);
      end else begin
        want_ev = pending_events.pop_front();
        if (got_ev !== want_ev) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("event mismatch: expected kind %0d slot %0d failed %0b last %0b,",
                     want_ev.kind, want_ev.slot, want_ev.failed, want_ev.last,
                     " got kind %0d slot %0d failed %0b last %0b",
                     got_ev.kind, got_ev.slot, got_ev.failed, got_ev.last);
        end
      end
    end
  end

  initial begin
    made_cnt = 0;
    for (int i = 0; i < TIMERS; i++) begin
      reload_val[i]  = '0;
      count_left[i]  = '0;
      is_periodic[i] = 1'b0;
      is_armed[i]    = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_bank();
    test_random(30, 1'b1);
    test_random(10, 1'b0);
    test_output_hold();
    test_drain_pause();
    test_random(10, 1'b1);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d items covering create, start, stop and tick, including full-bank and",
             n_items);
    $display("out-of-range errors; checked %0d events, %0d of them expiries.",
             n_events, n_expiries);
    if (fail_cnt == 0) begin
      $display("multi_channel_tick_timer_bank_top regression: pass");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("multi_channel_tick_timer_bank_top regression: fail");
    end
    $finish;
  end

endmodule
